/* rtl/mbhf_pkg.sv */
// Shared types, widths, codes and mask functions for the monochrome
// bitmap horizontal line fill block. No dependencies.
package mbhf_pkg;

   localparam int XW     = 13;  // pixel column width
   localparam int ROW_W  = 10;  // row index width
   localparam int BA_W   = 10;  // read byte address width
   localparam int RB_W   = 11;  // row_bytes register width
   localparam int PROD_W = ROW_W + RB_W;
   localparam int SW     = PROD_W + 1;  // shared adder width
   localparam int REQ_W  = 48;
   localparam int PIX_W  = 8;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [PIX_W-1:0] FULL_BYTE = 8'hFF;

   typedef struct packed {
      logic [SW-1:0] a;
      logic [SW-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [SW-1:0] sum;
      logic          fits;   // sum does not exceed the buffer size
   } alu_rsp_type;

   function automatic logic [PIX_W-1:0] head_bits(input logic [2:0] bit_pos);
      return FULL_BYTE << bit_pos;
   endfunction

   function automatic logic [PIX_W-1:0] tail_bits(input logic [2:0] bit_pos);
      return FULL_BYTE >> (3'd7 - bit_pos);
   endfunction

endpackage

/* rtl/mbhf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbhf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mbhf_alu.sv */
// Shared adder of the span sequencer: address sums, index advance and
// the row-fits-in-buffer check. Depends on mbhf_pkg.
module mbhf_alu #(
   parameter int LIMIT = 1024
) (
   input  mbhf_pkg::alu_req_type req,
   output mbhf_pkg::alu_rsp_type rsp
);

   localparam logic [mbhf_pkg::SW-1:0] LIMIT_V = mbhf_pkg::SW'(LIMIT);

   logic [mbhf_pkg::SW-1:0] sum;

   assign sum      = req.a + req.b;
   assign rsp.sum  = sum;
   assign rsp.fits = (sum <= LIMIT_V);

endmodule

/* rtl/mono_bitmap_hline_fill.sv */
// Monochrome frame buffer with horizontal span drawing, top level.
// Depends on mbhf_pkg, mbhf_alu and mbhf_ram.
//
// Request channel (req_*): one transfer per item. req_tuser selects draw or
// read; req_tdata carries the span and the read address. Response channel
// (rsp_*): exactly one transfer per request, rsp_tuser is ok and rsp_tdata
// the byte read (zero for draws and rejected reads).
// Configuration (csr_*): writes row_bytes; always ready, write only when idle.
//
// A draw runs the setup steps (multiply, checks, first and last address),
// then writes each inner byte directly and each end byte by read-modify-write
// through the single RAM port pair, then posts the result. A rejected draw
// goes to posting straight after the checks; a read fetches the byte and posts it.
// The request side is not ready while an item is in work.
//
// After reset the frame buffer is cleared one byte per cycle; no request is
// taken meanwhile. A finished result sits in the output register until
// taken; a stalled receiver stalls the block only when the next result is
// ready to post.
module mono_bitmap_hline_fill #(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [12:0] x_start, [25:13] x_end, [35:26] row, [45:36] byte_address
   input  logic [mbhf_pkg::REQ_W-1:0]     req_tdata,
   // [0] operation
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] read_data
   output logic [mbhf_pkg::PIX_W-1:0]     rsp_tdata,
   // [0] ok
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mbhf_pkg::RB_W-1:0]      csr_data
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_BYTES - 1);
   localparam logic [16:0]   BUF_LIM   = 17'(BUFFER_BYTES);

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_CHK   = 4'd3;
   localparam logic [3:0] ST_FST   = 4'd4;
   localparam logic [3:0] ST_LST   = 4'd5;
   localparam logic [3:0] ST_WALK  = 4'd6;
   localparam logic [3:0] ST_MOD   = 4'd7;
   localparam logic [3:0] ST_RDA   = 4'd8;
   localparam logic [3:0] ST_RDD   = 4'd9;
   localparam logic [3:0] ST_RESP  = 4'd10;

   logic [3:0]                     state_ff, state_in;
   logic [mbhf_pkg::RB_W-1:0]      rb_ff;
   logic [mbhf_pkg::XW-1:0]        xs_ff, xs_in, xe_ff, xe_in;
   logic [mbhf_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [mbhf_pkg::BA_W-1:0]      ba_ff, ba_in;
   logic [mbhf_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [AW-1:0]                  first_ff, first_in, last_ff, last_in;
   logic [AW-1:0]                  idx_ff, idx_in, clr_ff, clr_in;
   logic                           res_ok_ff, res_ok_in;
   logic [mbhf_pkg::PIX_W-1:0]     res_data_ff, res_data_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_ok_ff, rsp_ok_in;
   logic [mbhf_pkg::PIX_W-1:0]     rsp_data_ff, rsp_data_in;

   mbhf_pkg::alu_req_type          alu_req;
   mbhf_pkg::alu_rsp_type          alu_rsp;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr, ram_raddr;
   logic [mbhf_pkg::PIX_W-1:0]     ram_wdata, ram_rdata;

   logic                           req_xfer, rsp_free, at_first, at_last;
   logic [16:0]                    req_ba_ext;
   logic [mbhf_pkg::PIX_W-1:0]     smask, emask, mask;

   mbhf_alu #(.LIMIT(BUFFER_BYTES)) u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   mbhf_ram #(.WIDTH(mbhf_pkg::PIX_W), .DEPTH(BUFFER_BYTES)) u_fb (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign req_ba_ext = {7'd0, req_tdata[45:36]};
   assign at_first   = (idx_ff == first_ff);
   assign at_last    = (idx_ff == last_ff);
   assign smask      = mbhf_pkg::head_bits(xs_ff[2:0]);
   assign emask      = mbhf_pkg::tail_bits(xe_ff[2:0]);

   always_comb begin
      if (first_ff == last_ff) begin
         mask = smask & emask;
      end else if (at_first) begin
         mask = smask;
      end else begin
         mask = emask;
      end
   end

   always_comb begin
      state_in     = state_ff;
      xs_in        = xs_ff;
      xe_in        = xe_ff;
      row_in       = row_ff;
      ba_in        = ba_ff;
      prod_in      = prod_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      res_ok_in    = res_ok_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      alu_req.a    = '0;
      alu_req.b    = '0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = mbhf_pkg::FULL_BYTE;
      ram_raddr    = idx_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               xs_in       = req_tdata[12:0];
               xe_in       = req_tdata[25:13];
               row_in      = req_tdata[35:26];
               ba_in       = req_tdata[45:36];
               res_data_in = '0;
               if (req_tuser == mbhf_pkg::OP_DRAW) begin
                  state_in = ST_MUL;
               end else if (req_ba_ext < BUF_LIM) begin
                  state_in = ST_RDA;
               end else begin
                  res_ok_in = 1'b0;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mbhf_pkg::PROD_W'(row_ff) * mbhf_pkg::PROD_W'(rb_ff);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            alu_req.a = mbhf_pkg::SW'(prod_ff);
            alu_req.b = mbhf_pkg::SW'(rb_ff);
            if (rb_ff == '0 || xs_ff > xe_ff || {1'b0, xe_ff} >= {rb_ff, 3'b000} ||
                !alu_rsp.fits) begin
               res_ok_in = 1'b0;
               state_in  = ST_RESP;
            end else begin
               state_in = ST_FST;
            end
         end
         ST_FST: begin
            alu_req.a = mbhf_pkg::SW'(prod_ff);
            alu_req.b = mbhf_pkg::SW'(xs_ff[mbhf_pkg::XW-1:3]);
            first_in  = alu_rsp.sum[AW-1:0];
            idx_in    = alu_rsp.sum[AW-1:0];
            state_in  = ST_LST;
         end
         ST_LST: begin
            alu_req.a = mbhf_pkg::SW'(prod_ff);
            alu_req.b = mbhf_pkg::SW'(xe_ff[mbhf_pkg::XW-1:3]);
            last_in   = alu_rsp.sum[AW-1:0];
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            alu_req.a = mbhf_pkg::SW'(idx_ff);
            alu_req.b = mbhf_pkg::SW'(1);
            if (at_first || at_last) begin
               state_in = ST_MOD;
            end else begin
               ram_we = 1'b1;
               idx_in = alu_rsp.sum[AW-1:0];
            end
         end
         ST_MOD: begin
            alu_req.a = mbhf_pkg::SW'(idx_ff);
            alu_req.b = mbhf_pkg::SW'(1);
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | mask;
            if (at_last) begin
               res_ok_in = 1'b1;
               state_in  = ST_RESP;
            end else begin
               idx_in   = alu_rsp.sum[AW-1:0];
               state_in = ST_WALK;
            end
         end
         ST_RDA: begin
            ram_raddr = AW'({7'd0, ba_ff});
            state_in  = ST_RDD;
         end
         ST_RDD: begin
            res_ok_in   = 1'b1;
            res_data_in = ram_rdata;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_data_in  = res_data_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rb_ff        <= mbhf_pkg::RB_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            rb_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      xs_ff       <= xs_in;
      xe_ff       <= xe_in;
      row_ff      <= row_in;
      ba_ff       <= ba_in;
      prod_ff     <= prod_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      res_ok_ff   <= res_ok_in;
      res_data_ff <= res_data_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request taken during buffer clear");

   a_write_in_span: assert property (@(posedge clock) disable iff (reset)
      (ram_we && (state_ff == ST_WALK || state_ff == ST_MOD)) |->
      (idx_ff >= first_ff && idx_ff <= last_ff))
      else $error("span write outside first..last");

   a_reject_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_data_ff == '0))
      else $error("rejected result carries data");

   a_post_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_RESP))
      else $error("result posted over a waiting one");

endmodule

/* tb/mbhf_checker.sv */
// Scoreboard for mono_bitmap_hline_fill: watches the request, response and
// configuration channels, predicts each response, compares field by field.
// Depends on mbhf_pkg.
module mbhf_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [12:0] x_start, [25:13] x_end, [35:26] row, [45:36] byte_address
   input  logic [mbhf_pkg::REQ_W-1:0]     req_tdata,
   // [0] operation
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [7:0] read_data
   input  logic [mbhf_pkg::PIX_W-1:0]     rsp_tdata,
   // [0] ok
   input  logic                           rsp_tuser,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [mbhf_pkg::RB_W-1:0]      csr_data,
   output int unsigned                    failures,
   output int unsigned                    replies_seen,
   output int unsigned                    replies_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB_BYTES = 1024;

   typedef struct packed {
      logic                       ok;
      logic [mbhf_pkg::PIX_W-1:0] pixels;
   } span_reply_type;

   logic [mbhf_pkg::PIX_W-1:0] bitmap [FB_BYTES];
   logic [mbhf_pkg::RB_W-1:0]  width_bytes;
   span_reply_type             owed_replies [$];
   int unsigned                fail_total = 0;
   int unsigned                seen_total = 0;

   function automatic logic paint_span(input int unsigned xs, input int unsigned xe,
                                       input int unsigned row);
      int unsigned                rows, base, lo, hi, i;
      logic [mbhf_pkg::PIX_W-1:0] head, tail;
      if (width_bytes == 0) return 1'b0;
      rows = FB_BYTES / width_bytes;
      if (xs > xe || xe >= width_bytes * 8 || row >= rows) return 1'b0;
      base = row * width_bytes;
      lo   = base + xs / 8;
      hi   = base + xe / 8;
      head = mbhf_pkg::FULL_BYTE << (xs % 8);
      tail = mbhf_pkg::FULL_BYTE >> (7 - xe % 8);
      if (lo == hi) begin
         bitmap[lo] = bitmap[lo] | (head & tail);
      end else begin
         bitmap[lo] = bitmap[lo] | head;
         bitmap[hi] = bitmap[hi] | tail;
         for (i = lo + 1; i < hi; i++) bitmap[i] = mbhf_pkg::FULL_BYTE;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      span_reply_type want;
      int unsigned    addr;
      if (reset) begin
         for (int i = 0; i < FB_BYTES; i++) bitmap[i] = '0;
         width_bytes = 11'd2;
         owed_replies.delete();
      end else begin
         if (csr_valid && csr_ready) width_bytes = csr_data;
         if (req_tvalid && req_tready) begin
            addr = 32'(req_tdata[45:36]);
            if (req_tuser == mbhf_pkg::OP_READ) begin
               want.ok     = (addr < FB_BYTES);
               want.pixels = want.ok ? bitmap[addr] : '0;
            end else begin
               want.ok     = paint_span(32'(req_tdata[12:0]), 32'(req_tdata[25:13]),
                                        32'(req_tdata[35:26]));
               want.pixels = '0;
            end
            owed_replies.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_total++;
            if (owed_replies.size() == 0) begin
               $error("unexpected response transfer: ok %0d, read_data 0x%02h",
                      rsp_tuser, rsp_tdata);
               fail_total++;
            end else begin
               want = owed_replies.pop_front();
               if (rsp_tuser !== want.ok) begin
                  $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_tuser);
                  fail_total++;
               end
               if (rsp_tdata !== want.pixels) begin
                  $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                         want.pixels, rsp_tdata);
                  fail_total++;
               end
            end
         end
      end
      failures     <= fail_total;
      replies_seen <= seen_total;
      replies_owed <= owed_replies.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the mono_bitmap_hline_fill testbench: clock, reset, span and read
// stimulus over several row widths, and the verdict.
// Depends on mbhf_pkg, mono_bitmap_hline_fill and mbhf_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB_BYTES = 1024;
   localparam int PHASES   = 11;

   typedef enum int {
      SINK_ALWAYS,
      SINK_HALF,
      SINK_SPARSE,
      SINK_PERIODIC
   } sink_mode_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [mbhf_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                           req_tuser  = mbhf_pkg::OP_DRAW;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [mbhf_pkg::PIX_W-1:0]     rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [mbhf_pkg::RB_W-1:0]      csr_data   = '0;

   int unsigned failures, replies_seen, replies_owed;
   int unsigned sent_total = 0;
   int          burst_left = 0;
   int          last_byte  = 0;

   sink_mode_type sink_mode = SINK_ALWAYS;
   int            mode_left = 0;
   logic [2:0]    sink_tick = '0;

   int phase_width [PHASES] = '{2, 1, 3, 7, 16, 64, 0, 2047, 1025, 200, 1024};
   int phase_items [PHASES] = '{250, 250, 250, 200, 250, 200, 30, 30, 30, 120, 60};

   mono_bitmap_hline_fill dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   mbhf_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .failures     (failures),
      .replies_seen (replies_seen),
      .replies_owed (replies_owed)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: switch between stall patterns at random intervals
   always @(posedge clock) begin
      sink_tick <= sink_tick + 3'd1;
      if (mode_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(3));
         mode_left <= $urandom_range(300, 20);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (sink_mode)
         SINK_ALWAYS: rsp_tready <= 1'b1;
         SINK_HALF:   rsp_tready <= 1'($urandom_range(1));
         SINK_SPARSE: rsp_tready <= ($urandom_range(3) == 0);
         default:     rsp_tready <= (sink_tick[1:0] != 2'd0);
      endcase
   end

   task automatic send_request(input logic op, input int unsigned xs, input int unsigned xe,
                               input int unsigned row, input int unsigned addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(6, 1);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(16, 1);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, 10'(addr), 10'(row), 13'(xe), 13'(xs)};
      do @(posedge clock); while (!req_tready);
      sent_total++;
      burst_left--;
   endtask

   task automatic write_row_bytes(input int unsigned value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (replies_seen != sent_total) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mbhf_pkg::RB_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request(input int rb);
      int pix_w, rows, pick, kind, span, xs, xe, row;
      pix_w = rb * 8;
      rows  = (rb == 0) ? 0 : FB_BYTES / rb;
      pick  = $urandom_range(99);
      if (pick < 35) begin
         if ($urandom_range(1))
            send_request(mbhf_pkg::OP_READ, $urandom, $urandom, $urandom,
                         (last_byte + $urandom_range(2)) % FB_BYTES);
         else
            send_request(mbhf_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 45 || rows == 0) begin
         send_request(mbhf_pkg::OP_DRAW, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 52) begin
         row  = $urandom_range(rows - 1);
         kind = $urandom_range(2);
         if (kind == 1 && pix_w < 8192) begin
            xs = $urandom_range(pix_w - 1);
            xe = $urandom_range(8191, pix_w);
         end else if (kind == 2 && rows < FB_BYTES) begin
            xs  = $urandom_range(pix_w - 1);
            xe  = $urandom_range(pix_w - 1, xs);
            row = $urandom_range(1023, rows);
         end else begin
            xs = $urandom_range(pix_w - 1, 1);
            xe = $urandom_range(xs - 1);
         end
         send_request(mbhf_pkg::OP_DRAW, xs, xe, row, $urandom);
      end else begin
         row  = $urandom_range(rows - 1);
         xs   = $urandom_range(pix_w - 1);
         kind = $urandom_range(19);
         if (kind < 10)      span = $urandom_range(7);
         else if (kind < 17) span = $urandom_range(40);
         else                span = $urandom_range(pix_w - 1);
         xe = (xs + span > pix_w - 1) ? pix_w - 1 : xs + span;
         last_byte = (row * rb + xs / 8) % FB_BYTES;
         send_request(mbhf_pkg::OP_DRAW, xs, xe, row, $urandom);
      end
   endtask

   initial begin
      int cycles;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset width of two bytes per row, 512 rows
      send_request(mbhf_pkg::OP_DRAW, 0, 0, 0, 0);
      send_request(mbhf_pkg::OP_DRAW, 15, 15, 511, 0);
      send_request(mbhf_pkg::OP_DRAW, 3, 5, 2, 0);
      send_request(mbhf_pkg::OP_DRAW, 5, 10, 3, 0);
      send_request(mbhf_pkg::OP_DRAW, 0, 15, 4, 0);
      send_request(mbhf_pkg::OP_DRAW, 9, 8, 5, 0);
      send_request(mbhf_pkg::OP_DRAW, 0, 16, 6, 0);
      send_request(mbhf_pkg::OP_DRAW, 0, 3, 512, 0);
      send_request(mbhf_pkg::OP_DRAW, 13'h1FFF, 13'h1FFF, 10'h3FF, 0);
      send_request(mbhf_pkg::OP_DRAW, 2, 6, 7, 10'h3FF);
      send_request(mbhf_pkg::OP_READ, 13'h1FFF, 13'h1FFF, 10'h3FF, 0);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 5);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 6);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 7);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 14);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 10'h3FF);

      for (int p = 0; p < PHASES; p++) begin
         write_row_bytes(phase_width[p]);
         for (int n = 0; n < phase_items[p]; n++) random_request(phase_width[p]);
      end

      // whole buffer is one row here; second row does not exist
      send_request(mbhf_pkg::OP_DRAW, 0, 7, 1, 0);
      send_request(mbhf_pkg::OP_DRAW, 0, 13'h1FFF, 0, 0);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 0);
      send_request(mbhf_pkg::OP_READ, 0, 0, 0, 10'h3FF);

      req_tvalid <= 1'b0;
      cycles = 0;
      while (replies_seen != sent_total && cycles < 50000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (40) @(posedge clock);
      if (failures == 0 && replies_owed == 0 && replies_seen == sent_total) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
